FILE: hdl/mwe_pkg.sv
// shared constants, codes and transaction types of the mask word enumerator
package mwe_pkg;

    localparam int MAX_POSITIONS = 16;
    localparam int MAX_SET       = 64;

    localparam int POS_W   = $clog2(MAX_POSITIONS);
    localparam int SLOT_W  = $clog2(MAX_SET);
    localparam int DIGIT_W = $clog2(MAX_SET);
    localparam int SIZE_W  = 7;
    localparam int CHAR_W  = 8;
    localparam int NPOS_W  = 5;
    localparam int ADDR_W  = POS_W + SLOT_W;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request type codes as they arrive on the input
    localparam logic [1:0] REQ_LOAD_CHAR = 2'd0;
    localparam logic [1:0] REQ_LOAD_SIZE = 2'd1;
    localparam logic [1:0] REQ_RESTART   = 2'd2;
    localparam logic [1:0] REQ_NEXT_WORD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_POSITIONS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR     = 1'd1;

    typedef enum logic [1:0] {
        OP_LOAD_CHAR,
        OP_LOAD_SIZE,
        OP_RESTART,
        OP_NEXT_WORD
    } op_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EMIT,
        B_SEP
    } back_state_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [POS_W-1:0]  position;
        logic [SLOT_W-1:0] slot;
        logic [CHAR_W-1:0] char_value;
        logic [SIZE_W-1:0] set_size;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
        logic              final_word;
        logic              exhausted;
    } result_t;

    // classified command held in the queue
    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  position;
        logic [SLOT_W-1:0] slot;
        logic [CHAR_W-1:0] char_value;
        logic [SIZE_W-1:0] set_size;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]  n_last;
        logic [CHAR_W-1:0] separator;
        logic              restart;
    } cfg_t;

endpackage

FILE: hdl/mwe_front.sv
// front end: accepts requests, classifies them and queues commands
module mwe_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mwe_pkg::req_t   req,
    output logic            cmd_valid,
    output mwe_pkg::cmd_t   cmd,
    input  logic            cmd_pop
);

    mwe_pkg::cmd_t                  q_reg [mwe_pkg::QUEUE_DEPTH];
    logic [mwe_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mwe_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mwe_pkg::QCNT_W-1:0]     count_reg, count_next;
    mwe_pkg::cmd_t                  cls;
    logic                           push;

    assign busy      = (count_reg == mwe_pkg::QCNT_W'(mwe_pkg::QUEUE_DEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    // decode and saturate the set size to 1..MAX_SET
    always_comb
    begin
        cls.position   = req.position;
        cls.slot       = req.slot;
        cls.char_value = req.char_value;
        if (req.set_size == '0)
            cls.set_size = mwe_pkg::SIZE_W'(1);
        else if (req.set_size > mwe_pkg::SIZE_W'(mwe_pkg::MAX_SET))
            cls.set_size = mwe_pkg::SIZE_W'(mwe_pkg::MAX_SET);
        else
            cls.set_size = req.set_size;
        unique case (req.req_type)
            mwe_pkg::REQ_LOAD_CHAR: cls.op = mwe_pkg::OP_LOAD_CHAR;
            mwe_pkg::REQ_LOAD_SIZE: cls.op = mwe_pkg::OP_LOAD_SIZE;
            mwe_pkg::REQ_RESTART:   cls.op = mwe_pkg::OP_RESTART;
            default:                cls.op = mwe_pkg::OP_NEXT_WORD;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (cmd_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !cmd_pop)
            count_next = count_reg + 1'b1;
        else if (!push && cmd_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

FILE: hdl/mwe_back.sv
// back end: set storage, odometer and byte emission
module mwe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mwe_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    input  mwe_pkg::cfg_t     cfg,
    output logic              result_strobe,
    output mwe_pkg::result_t  result
);

    mwe_pkg::back_state_t          state_reg, state_next;
    logic [mwe_pkg::POS_W-1:0]     p_reg, p_next;
    logic                          carry_reg, carry_next;
    logic                          fin_reg, fin_next;
    logic                          done_reg, done_next;
    logic [mwe_pkg::DIGIT_W-1:0]   digits_reg [mwe_pkg::MAX_POSITIONS];
    logic [mwe_pkg::DIGIT_W-1:0]   digits_next [mwe_pkg::MAX_POSITIONS];
    logic [mwe_pkg::SIZE_W-1:0]    sizes_reg [mwe_pkg::MAX_POSITIONS];
    logic [mwe_pkg::SIZE_W-1:0]    sizes_next [mwe_pkg::MAX_POSITIONS];
    logic                          res_valid_reg, res_valid_next;
    logic                          src_mem_reg, src_mem_next;
    mwe_pkg::result_t              res_reg, res_next;

    logic [mwe_pkg::CHAR_W-1:0]    chars_mem [2**mwe_pkg::ADDR_W];
    logic [mwe_pkg::CHAR_W-1:0]    mem_rd_reg;
    logic                          mem_we, mem_re;
    logic [mwe_pkg::ADDR_W-1:0]    mem_waddr, mem_raddr;

    logic [mwe_pkg::MAX_POSITIONS-1:0] at_max;
    logic                          fin_now;
    logic [mwe_pkg::DIGIT_W-1:0]   cur_digit;
    logic [mwe_pkg::SIZE_W-1:0]    cur_inc;

    // final word when every active digit sits at its top value
    always_comb
    begin
        for (int i = 0; i < mwe_pkg::MAX_POSITIONS; i++)
        begin
            at_max[i] = ((mwe_pkg::SIZE_W'(digits_reg[i]) + mwe_pkg::SIZE_W'(1)) == sizes_reg[i])
                        || (mwe_pkg::POS_W'(i) > cfg.n_last);
        end
        fin_now = &at_max;
    end

    assign cur_digit = digits_reg[p_reg];
    assign cur_inc   = mwe_pkg::SIZE_W'(cur_digit) + mwe_pkg::SIZE_W'(1);
    assign cmd_pop   = (state_reg == mwe_pkg::B_IDLE) && cmd_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwe_pkg::B_IDLE:
            begin
                if (cmd_valid && (cmd.op == mwe_pkg::OP_NEXT_WORD) && !done_reg)
                    state_next = mwe_pkg::B_EMIT;
            end
            mwe_pkg::B_EMIT:
            begin
                if (p_reg == cfg.n_last)
                    state_next = mwe_pkg::B_SEP;
            end
            mwe_pkg::B_SEP:
                state_next = mwe_pkg::B_IDLE;
            default:
                state_next = mwe_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        p_next         = p_reg;
        carry_next     = carry_reg;
        fin_next       = fin_reg;
        done_next      = done_reg;
        digits_next    = digits_reg;
        sizes_next     = sizes_reg;
        res_valid_next = 1'b0;
        src_mem_next   = src_mem_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = {cmd.position, cmd.slot};
        mem_raddr      = {p_reg, cur_digit};

        unique case (state_reg)
            mwe_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        mwe_pkg::OP_LOAD_CHAR:
                            mem_we = 1'b1;
                        mwe_pkg::OP_LOAD_SIZE:
                        begin
                            sizes_next[cmd.position] = cmd.set_size;
                            for (int i = 0; i < mwe_pkg::MAX_POSITIONS; i++)
                                digits_next[i] = '0;
                            done_next = 1'b0;
                        end
                        mwe_pkg::OP_RESTART:
                        begin
                            for (int i = 0; i < mwe_pkg::MAX_POSITIONS; i++)
                                digits_next[i] = '0;
                            done_next = 1'b0;
                        end
                        default:
                        begin
                            if (done_reg)
                            begin
                                res_valid_next = 1'b1;
                                src_mem_next   = 1'b0;
                                res_next       = '{out_char: '0, last: 1'b1,
                                                   final_word: 1'b0, exhausted: 1'b1};
                            end
                            else
                            begin
                                p_next     = '0;
                                carry_next = 1'b1;
                                fin_next   = fin_now;
                            end
                        end
                    endcase
                end
            end
            mwe_pkg::B_EMIT:
            begin
                // read the current character, then ripple the carry one position
                mem_re         = 1'b1;
                res_valid_next = 1'b1;
                src_mem_next   = 1'b1;
                res_next       = '{out_char: '0, last: 1'b0,
                                   final_word: fin_reg, exhausted: 1'b0};
                if (carry_reg)
                begin
                    if (cur_inc < sizes_reg[p_reg])
                    begin
                        digits_next[p_reg] = cur_inc[mwe_pkg::DIGIT_W-1:0];
                        carry_next         = 1'b0;
                    end
                    else
                        digits_next[p_reg] = '0;
                end
                p_next = p_reg + 1'b1;
            end
            mwe_pkg::B_SEP:
            begin
                res_valid_next = 1'b1;
                src_mem_next   = 1'b0;
                res_next       = '{out_char: cfg.separator, last: 1'b1,
                                   final_word: fin_reg, exhausted: 1'b0};
                // carry out of the top position means the mask is used up
                done_next      = carry_reg;
            end
            default:
            begin
            end
        endcase

        if (cfg.restart)
        begin
            for (int i = 0; i < mwe_pkg::MAX_POSITIONS; i++)
                digits_next[i] = '0;
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mwe_pkg::B_IDLE;
            p_reg         <= '0;
            carry_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            src_mem_reg   <= 1'b0;
            for (int i = 0; i < mwe_pkg::MAX_POSITIONS; i++)
            begin
                digits_reg[i] <= '0;
                sizes_reg[i]  <= mwe_pkg::SIZE_W'(1);
            end
        end
        else
        begin
            state_reg     <= state_next;
            p_reg         <= p_next;
            carry_reg     <= carry_next;
            fin_reg       <= fin_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
            src_mem_reg   <= src_mem_next;
            digits_reg    <= digits_next;
            sizes_reg     <= sizes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            chars_mem[mem_waddr] <= cmd.char_value;
        if (mem_re)
            mem_rd_reg <= chars_mem[mem_raddr];
    end

    assign result_strobe     = res_valid_reg;
    assign result.out_char   = src_mem_reg ? mem_rd_reg : res_reg.out_char;
    assign result.last       = res_reg.last;
    assign result.final_word = res_reg.final_word;
    assign result.exhausted  = res_reg.exhausted;

endmodule

FILE: hdl/mask_word_enumerator_unit.sv
// top level of the mask word enumerator: configuration registers and front/back split
//
//  channel   ports                                  transaction
//  request   start, busy, req                       start high while busy low
//  result    result_strobe, result                  strobe high for a single cycle per byte, no back-pressure
//  config    cfg_we, cfg_index, cfg_data            cfg_we high, no wait
//
//  a next-word request is popped in the idle state, then the back end emits one byte per
//  cycle from the registered read of the character memory, one per active position, and
//  then the separator; loads, restarts and exhausted answers finish as they are popped.
//  the two-entry command queue lets requests arrive while a word is being emitted;
//  busy rises only when it is full. reset gives set sizes of one, digits of zero,
//  one position and a line-feed separator; set characters hold nothing until loaded.
module mask_word_enumerator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mwe_pkg::req_t                     req,
    output logic                              result_strobe,
    output mwe_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [mwe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mwe_pkg::CFG_W-1:0]         cfg_data
);

    logic [mwe_pkg::POS_W-1:0]   n_last_reg, n_last_next;
    logic [mwe_pkg::CHAR_W-1:0]  sep_reg, sep_next;
    logic [mwe_pkg::NPOS_W-1:0]  npos_raw;
    logic                        restart;
    mwe_pkg::cfg_t               cfg;
    mwe_pkg::cmd_t               cmd;
    logic                        cmd_valid;
    logic                        cmd_pop;

    assign npos_raw = cfg_data[mwe_pkg::NPOS_W-1:0];

    // position count is stored as the index of the last active position
    always_comb
    begin
        n_last_next = n_last_reg;
        sep_next    = sep_reg;
        restart     = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                mwe_pkg::CFG_NUM_POSITIONS:
                begin
                    restart = 1'b1;
                    if (npos_raw == '0)
                        n_last_next = '0;
                    else if (npos_raw > mwe_pkg::NPOS_W'(mwe_pkg::MAX_POSITIONS))
                        n_last_next = mwe_pkg::POS_W'(mwe_pkg::MAX_POSITIONS - 1);
                    else
                        n_last_next = mwe_pkg::POS_W'(npos_raw - 1'b1);
                end
                mwe_pkg::CFG_SEPARATOR:
                    sep_next = cfg_data[mwe_pkg::CHAR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_last_reg <= '0;
            sep_reg    <= mwe_pkg::CHAR_W'(10);
        end
        else
        begin
            n_last_reg <= n_last_next;
            sep_reg    <= sep_next;
        end
    end

    assign cfg.n_last    = n_last_reg;
    assign cfg.separator = sep_reg;
    assign cfg.restart   = restart;

    mwe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    mwe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .cfg           (cfg),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule
